// ===== design/amic_pkg.sv =====
// ----------------------------------------------------------------------------
// amic_pkg
// Shared types, codes and the control store of the almost-inverse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package amic_pkg;

  // Field widths of the item formats
  localparam int unsigned IN_FIELD_W  = 15;
  localparam int unsigned COEF_W      = 17;
  localparam int unsigned RESULT_W    = 16;
  localparam int unsigned ITER_W      = 6;
  localparam int unsigned ADD_W       = 6;
  localparam int unsigned SUB_W       = 7;
  localparam int unsigned SHIFT_W     = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned OUT_FIELD_W =
    STATUS_W + RESULT_W + ITER_W + ADD_W + SUB_W + SHIFT_W;

  // Safety stop on the iteration counter
  localparam logic [ITER_W-1:0] ITER_LIMIT = 6'd63;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW_ONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABOVE_MOD = 2'd2;

  // Sequencer step addresses
  localparam int unsigned STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 2'd1;
  localparam logic [STEP_W-1:0] STEP_ITER  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd3;

  // Datapath operations
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;  // wait for an item, load operands
  localparam logic [OP_W-1:0] OP_CHECK = 2'd1;  // branch on bad status
  localparam logic [OP_W-1:0] OP_ITER  = 2'd2;  // one loop iteration, branch when done
  localparam logic [OP_W-1:0] OP_EMIT  = 2'd3;  // move result to output register

  // One control word: operation, fall-through step, branch step
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] next_step;
    logic [STEP_W-1:0] branch_step;
  } ctrl_word_t;

  // Control store
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    case (step)
      STEP_WAIT:  cw = '{op: OP_LOAD,  next_step: STEP_CHECK, branch_step: STEP_WAIT};
      STEP_CHECK: cw = '{op: OP_CHECK, next_step: STEP_ITER,  branch_step: STEP_EMIT};
      STEP_ITER:  cw = '{op: OP_ITER,  next_step: STEP_ITER,  branch_step: STEP_EMIT};
      STEP_EMIT:  cw = '{op: OP_EMIT,  next_step: STEP_WAIT,  branch_step: STEP_EMIT};
      default:    cw = '{op: OP_LOAD,  next_step: STEP_WAIT,  branch_step: STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== design/almost_montgomery_inverse_counter.sv =====
// ----------------------------------------------------------------------------
// almost_montgomery_inverse_counter
// Phase one of the almost-Montgomery inverse with operation counters.
// ----------------------------------------------------------------------------
// Each input item carries an operand a and a modulus p. If 1 <= a <= p the
// block runs u = p, v = a, r = 0, s = 1 until u equals v (or 63 iterations
// pass) and returns r with counts of iterations, additions, subtractions and
// shifts; otherwise it returns an error status with r and all counts zero.
// A small microprogram sequences load, check, iterate and emit; the iterate
// step loops on itself and does one loop iteration per clock. After an item
// is accepted, a run that stops on u equal v passes through one check step,
// one iterate step per iteration, one iterate step for the final compare and
// one emit step; a run that stops at the 63-iteration guard has no final
// compare step, and a rejected item passes through the check and emit steps
// only. Iterations stay at about 30 or fewer for 15-bit values. The emit
// step waits while the previous result is still held. The next item is
// accepted as soon as the result sits in the output register, even while it
// waits to be taken.
`default_nettype none

module almost_montgomery_inverse_counter #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [14:0] operand, [29:15] modulus
  input  wire logic [amic_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [1:0] status, [17:2] almost_inverse, [23:18] iterations,
  // [29:24] additions, [36:30] subtractions, [43:37] shifts
  output logic [amic_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import amic_pkg::*;

  // Sequencer
  logic [STEP_W-1:0]      step;
  logic [STEP_W-1:0]      step_next;
  ctrl_word_t             cw;

  // Working registers
  logic [VALUE_WIDTH-1:0] work_u;
  logic [VALUE_WIDTH-1:0] work_v;
  logic [COEF_W-1:0]      coef_r;
  logic [COEF_W-1:0]      coef_s;
  logic [ITER_W-1:0]      iter_count;
  logic [ADD_W-1:0]       add_count;
  logic [SUB_W-1:0]       sub_count;
  logic [SHIFT_W-1:0]     shift_count;
  logic [STATUS_W-1:0]    status;

  // Input fields
  logic [IN_FIELD_W-1:0]  operand;
  logic [IN_FIELD_W-1:0]  modulus;
  logic [STATUS_W-1:0]    in_status;
  logic                   in_accept;

  // Iteration datapath
  logic [VALUE_WIDTH-1:0] diff_uv;
  logic [VALUE_WIDTH-1:0] diff_vu;
  logic [COEF_W-1:0]      coef_sum;
  logic [ITER_W-1:0]      iter_inc;
  logic                   both_odd;
  logic                   uv_equal;
  logic                   iter_done;
  logic                   out_free;

  assign operand = s_tdata[IN_FIELD_W-1:0];
  assign modulus = s_tdata[2*IN_FIELD_W-1:IN_FIELD_W];

  assign cw        = ucode(step);
  assign s_tready  = (cw.op == OP_LOAD);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Operand range check
  always_comb begin
    if (operand == '0) begin
      in_status = STATUS_BELOW_ONE;
    end else if (operand > modulus) begin
      in_status = STATUS_ABOVE_MOD;
    end else begin
      in_status = STATUS_OK;
    end
  end

  // One loop iteration
  assign diff_uv   = work_u - work_v;
  assign diff_vu   = work_v - work_u;
  assign coef_sum  = coef_r + coef_s;
  assign iter_inc  = iter_count + ITER_W'(1);
  assign both_odd  = work_u[0] && work_v[0];
  assign uv_equal  = (work_u == work_v);
  assign iter_done = (both_odd && uv_equal) || (iter_inc == ITER_LIMIT);

  // Next step from the control word
  always_comb begin
    step_next = step;
    case (cw.op)
      OP_LOAD: begin
        if (in_accept) step_next = cw.next_step;
      end
      OP_CHECK: begin
        step_next = (status != STATUS_OK) ? cw.branch_step : cw.next_step;
      end
      OP_ITER: begin
        step_next = iter_done ? cw.branch_step : cw.next_step;
      end
      OP_EMIT: begin
        if (out_free) step_next = cw.next_step;
      end
      default: step_next = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // Working register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      work_u      <= '0;
      work_v      <= '0;
      coef_r      <= '0;
      coef_s      <= '0;
      iter_count  <= '0;
      add_count   <= '0;
      sub_count   <= '0;
      shift_count <= '0;
      status      <= STATUS_OK;
    end else if (cw.op == OP_LOAD && in_accept) begin
      work_u      <= VALUE_WIDTH'(modulus);
      work_v      <= VALUE_WIDTH'(operand);
      coef_r      <= '0;
      coef_s      <= COEF_W'(1);
      iter_count  <= '0;
      add_count   <= '0;
      sub_count   <= '0;
      shift_count <= '0;
      status      <= in_status;
    end else if (cw.op == OP_ITER) begin
      if (!work_u[0]) begin
        work_u      <= work_u >> 1;
        coef_s      <= coef_s << 1;
        shift_count <= shift_count + SHIFT_W'(2);
        iter_count  <= iter_inc;
      end else if (!work_v[0]) begin
        work_v      <= work_v >> 1;
        coef_r      <= coef_r << 1;
        shift_count <= shift_count + SHIFT_W'(2);
        iter_count  <= iter_inc;
      end else if (uv_equal) begin
        // stop: the final compare counts as one subtract and one add
        sub_count   <= sub_count + SUB_W'(1);
        add_count   <= add_count + ADD_W'(1);
      end else if (work_u > work_v) begin
        work_u      <= diff_uv >> 1;
        coef_r      <= coef_sum;
        coef_s      <= coef_s << 1;
        sub_count   <= sub_count + SUB_W'(1);
        add_count   <= add_count + ADD_W'(1);
        shift_count <= shift_count + SHIFT_W'(2);
        iter_count  <= iter_inc;
      end else begin
        work_v      <= diff_vu >> 1;
        coef_s      <= coef_sum;
        coef_r      <= coef_r << 1;
        sub_count   <= sub_count + SUB_W'(2);
        add_count   <= add_count + ADD_W'(1);
        shift_count <= shift_count + SHIFT_W'(2);
        iter_count  <= iter_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cw.op == OP_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && out_free) begin
      m_tdata <= {(OUT_DATA_W - OUT_FIELD_W)'(0), shift_count, sub_count, add_count,
                  iter_count, coef_r[RESULT_W-1:0], status};
    end
  end

  // Checks
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (step == STEP_CHECK))
    else $error("accepted item did not move to the check step");

  a_iter_status_ok: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_ITER) |-> (status == STATUS_OK))
    else $error("iterating on a rejected item");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT && out_free) |=> (m_tvalid && step == STEP_WAIT))
    else $error("emit step did not present a result");

  a_error_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[STATUS_W-1:0] != STATUS_OK) |-> (m_tdata[OUT_DATA_W-1:STATUS_W] == '0))
    else $error("rejected item carries nonzero result fields");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the almost-Montgomery inverse counter.
// ----------------------------------------------------------------------------
// A short directed set covers the error statuses, equal operands, the field
// extremes and operands and moduli that give long runs of even values. A long random set
// follows, mostly well-formed operand and modulus pairs of random bit length.
// Every accepted item is predicted in the scoreboard. Every result is
// compared field by field with the oldest prediction. Both sides of the
// stream idle at random, with one stretch where neither side idles.

module testbench;

  import amic_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One result item, unpacked into its fields
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [RESULT_W-1:0] almost_inverse;
    logic [ITER_W-1:0]   iterations;
    logic [ADD_W-1:0]    additions;
    logic [SUB_W-1:0]    subtractions;
    logic [SHIFT_W-1:0]  shifts;
  } amic_result_t;

  // Predicts one result per accepted item and checks results in order
  class inverse_scoreboard;
    amic_result_t pending_results[$];
    int unsigned  mismatches = 0;

    // Phase one of the almost-Montgomery inverse with operation counts
    function amic_result_t compute_almost_inverse(input logic [IN_FIELD_W-1:0] a,
                                                  input logic [IN_FIELD_W-1:0] p);
      amic_result_t    res;
      logic [15:0]     u;
      logic [15:0]     v;
      logic [COEF_W-1:0] r;
      logic [COEF_W-1:0] s;
      logic [COEF_W-1:0] sum;
      logic [ITER_W-1:0] k;
      logic [ADD_W-1:0]  adds;
      logic [SUB_W-1:0]  subs;
      logic [SHIFT_W-1:0] shf;
      bit              done;
      res.status         = STATUS_OK;
      res.almost_inverse = '0;
      res.iterations     = '0;
      res.additions      = '0;
      res.subtractions   = '0;
      res.shifts         = '0;
      if (a == 0) begin
        res.status = STATUS_BELOW_ONE;
        return res;
      end
      if (a > p) begin
        res.status = STATUS_ABOVE_MOD;
        return res;
      end
      u = 16'(p);
      v = 16'(a);
      r = '0;
      s = 17'd1;
      k = '0;
      adds = '0;
      subs = '0;
      shf = '0;
      done = 1'b0;
      while (!done) begin
        if (!u[0]) begin
          u = u >> 1;
          s = s << 1;
          shf += 7'd2;
        end else if (!v[0]) begin
          v = v >> 1;
          r = r << 1;
          shf += 7'd2;
        end else begin
          // the difference is formed even when it turns out to be zero
          sum = r + s;
          subs += 7'd1;
          adds += 6'd1;
          if (u == v) begin
            done = 1'b1;
          end else begin
            if (u > v) begin
              u = 16'(u - v) >> 1;
              r = sum;
              s = s << 1;
            end else begin
              subs += 7'd1;
              v = 16'(v - u) >> 1;
              s = sum;
              r = r << 1;
            end
            shf += 7'd2;
          end
        end
        // stopping on equality does not complete the iteration
        if (!done) begin
          k += 6'd1;
          if (k >= ITER_LIMIT) done = 1'b1;
        end
      end
      res.almost_inverse = r[RESULT_W-1:0];
      res.iterations     = k;
      res.additions      = adds;
      res.subtractions   = subs;
      res.shifts         = shf;
      return res;
    endfunction

    function void note_operands(input logic [IN_FIELD_W-1:0] a,
                                input logic [IN_FIELD_W-1:0] p);
      pending_results.push_back(compute_almost_inverse(a, p));
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] word);
      amic_result_t got;
      amic_result_t exp;
      got.status         = word[1:0];
      got.almost_inverse = word[17:2];
      got.iterations     = word[23:18];
      got.additions      = word[29:24];
      got.subtractions   = word[36:30];
      got.shifts         = word[43:37];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result st=%0d r=%0d k=%0d add=%0d sub=%0d shf=%0d",
                   $realtime, got.status, got.almost_inverse, got.iterations,
                   got.additions, got.subtractions, got.shifts);
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status || got.almost_inverse !== exp.almost_inverse ||
          got.iterations !== exp.iterations || got.additions !== exp.additions ||
          got.subtractions !== exp.subtractions || got.shifts !== exp.shifts) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  exp st=%0d r=%0d k=%0d add=%0d sub=%0d shf=%0d",
                   exp.status, exp.almost_inverse, exp.iterations,
                   exp.additions, exp.subtractions, exp.shifts);
          $display("  got st=%0d r=%0d k=%0d add=%0d sub=%0d shf=%0d",
                   got.status, got.almost_inverse, got.iterations,
                   got.additions, got.subtractions, got.shifts);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [14:0] operand, [29:15] modulus
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [1:0] status, [17:2] almost_inverse, [23:18] iterations,
  // [29:24] additions, [36:30] subtractions, [43:37] shifts
  logic [OUT_DATA_W-1:0] m_tdata;

  bit                    steady = 1'b0;
  int unsigned           idle_cycles = 0;
  inverse_scoreboard     sb = new;

  almost_montgomery_inverse_counter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 24);
  end

  // Monitor both sides and watch for a stalled run
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_operands(s_tdata[14:0], s_tdata[29:15]);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one item, with random idle cycles first, and wait for acceptance
  task automatic send_item(input logic [IN_FIELD_W-1:0] a, input logic [IN_FIELD_W-1:0] p);
    while (!steady && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, p, a};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stimulus
  initial begin
    int unsigned sel;
    int unsigned len;
    int unsigned a;
    int unsigned p;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // error statuses
    send_item(15'd0, 15'd0);
    send_item(15'd0, 15'd32767);
    send_item(15'd1, 15'd0);
    send_item(15'd32767, 15'd32766);
    send_item(15'd5, 15'd3);
    // equal operands, odd and even
    send_item(15'd1, 15'd1);
    send_item(15'd2, 15'd2);
    send_item(15'd32767, 15'd32767);
    send_item(15'd16384, 15'd16384);
    // field extremes and long even runs
    send_item(15'd1, 15'd32767);
    send_item(15'd2, 15'd32767);
    send_item(15'd16384, 15'd32767);
    send_item(15'd32766, 15'd32767);
    send_item(15'd1, 15'd16384);
    send_item(15'd1, 15'd2);
    send_item(15'h5555, 15'd32767);
    send_item(15'h2AAA, 15'd32767);
    send_item(15'd12345, 15'd32749);
    send_item(15'd3, 15'd7);
    send_item(15'd6, 15'd7);

    // random part: mostly valid pairs with an odd modulus of random length
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 700 && n < 1000);
      sel = $urandom_range(0, 99);
      len = $urandom_range(1, 15);
      p   = $urandom_range(1, (1 << len) - 1);
      if (sel < 80) begin
        p = p | 1;
        a = $urandom_range(1, p);
      end else if (sel < 88) begin
        a = $urandom_range(1, p);
      end else if (sel < 92) begin
        a = 0;
        p = $urandom_range(0, 32767);
      end else begin
        if (p == 32767) p = $urandom_range(0, 32766);
        a = $urandom_range(p + 1, 32767);
      end
      send_item(a[IN_FIELD_W-1:0], p[IN_FIELD_W-1:0]);
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk);

    // drain and let the block settle
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.mismatches += sb.pending_results.size();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
